// ===== hdl/cqr_pkg.sv =====
`timescale 1ns / 1ps

package cqr_pkg;

  // Queue geometry and word format
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SWP_W      = CNT_W - 1;
  localparam int CMD_W      = 2;
  localparam int ERR_W      = 2;

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

  // Front value reported for an empty queue
  localparam logic signed [DATA_WIDTH-1:0] INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Operation codes
  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REV = 2'd2;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;

  // Pointer selects for the storage port
  localparam logic [1:0] PSEL_HEAD = 2'd0;
  localparam logic [1:0] PSEL_TAIL = 2'd1;
  localparam logic [1:0] PSEL_LO   = 2'd2;
  localparam logic [1:0] PSEL_HI   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic             accept;     // latch item, clear removed value
    logic [ERR_W-1:0] err;        // error code of the accepted item
    logic             rev_start;  // load swap pointers and swap count
    logic             mem_rd;
    logic             mem_wr;
    logic [1:0]       psel;       // pointer that addresses the storage
    logic             enq_commit;
    logic             deq_commit;
    logic             swap_save;  // hold low word of the current swap
    logic             swap_step;  // move swap pointers inward
    logic             load_out;   // load result register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic one_entry;
    logic swap_last;
  } dp_stat_t;

endpackage

// ===== hdl/cqr_ifs.sv =====
`timescale 1ns / 1ps

// Command channel
interface cqr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [cqr_pkg::CMD_W-1:0]             cmd;
  logic signed [cqr_pkg::DATA_WIDTH-1:0] item_value;

  modport source (output valid, output cmd, output item_value, input ready);
  modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

// Result channel
interface cqr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cqr_pkg::DATA_WIDTH-1:0] removed_value;
  logic signed [cqr_pkg::DATA_WIDTH-1:0] front_value;
  logic [cqr_pkg::CNT_W-1:0]             entry_count;
  logic                                  is_empty;
  logic                                  is_full;
  logic [cqr_pkg::ERR_W-1:0]             error_code;

  modport source (output valid, output removed_value, output front_value,
                  output entry_count, output is_empty, output is_full,
                  output error_code, input ready);
  modport sink   (input valid, input removed_value, input front_value,
                  input entry_count, input is_empty, input is_full,
                  input error_code, output ready);
endinterface

// ===== hdl/cqr_datapath.sv =====
`timescale 1ns / 1ps

module cqr_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cqr_pkg::ctl_cmd_t                     cmd,
  output cqr_pkg::dp_stat_t                     stat,
  input  logic signed [cqr_pkg::DATA_WIDTH-1:0] in_item_value,
  output logic signed [cqr_pkg::DATA_WIDTH-1:0] out_removed_value,
  output logic signed [cqr_pkg::DATA_WIDTH-1:0] out_front_value,
  output logic [cqr_pkg::CNT_W-1:0]             out_entry_count,
  output logic                                  out_is_empty,
  output logic                                  out_is_full,
  output logic [cqr_pkg::ERR_W-1:0]             out_error_code
);
  import cqr_pkg::*;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - PTR_W'(1);
  endfunction

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];

  logic [PTR_W-1:0]             head_r, tail_r, lo_r, hi_r;
  logic [CNT_W-1:0]             count_r;
  logic [SWP_W-1:0]             swaps_r;
  logic signed [DATA_WIDTH-1:0] item_r, removed_r, rd_data_r, lo_data_r;
  logic [ERR_W-1:0]             err_r;
  logic [PTR_W-1:0]             addr;
  logic signed [DATA_WIDTH-1:0] wr_data;

  // Pick the storage address and write word
  always_comb begin
    unique case (cmd.psel)
      PSEL_HEAD: begin
        addr    = head_r;
        wr_data = item_r;
      end
      PSEL_TAIL: begin
        addr    = tail_r;
        wr_data = item_r;
      end
      PSEL_LO: begin
        addr    = lo_r;
        wr_data = rd_data_r;
      end
      default: begin
        addr    = hi_r;
        wr_data = lo_data_r;
      end
    endcase
  end

  // Storage write
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wr_data;
    end
  end

  // Storage read, data registered
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_data_r <= mem[addr];
    end
  end

  // Queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.enq_commit) begin
        tail_r  <= ptr_inc(tail_r);
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.deq_commit) begin
        head_r  <= ptr_inc(head_r);
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Item latch, removed value and swap bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r    <= in_item_value;
      err_r     <= cmd.err;
      removed_r <= '0;
    end
    if (cmd.deq_commit) begin
      removed_r <= rd_data_r;
    end
    if (cmd.rev_start) begin
      lo_r    <= head_r;
      hi_r    <= ptr_dec(tail_r);
      swaps_r <= count_r[CNT_W-1:1];
    end else if (cmd.swap_step) begin
      lo_r    <= ptr_inc(lo_r);
      hi_r    <= ptr_dec(hi_r);
      swaps_r <= swaps_r - SWP_W'(1);
    end
    if (cmd.swap_save) begin
      lo_data_r <= rd_data_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_removed_value <= removed_r;
      out_front_value   <= (count_r == '0) ? INT_MIN : rd_data_r;
      out_entry_count   <= count_r;
      out_is_empty      <= (count_r == '0);
      out_is_full       <= (count_r == CNT_FULL);
      out_error_code    <= err_r;
    end
  end

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CNT_FULL);
  assign stat.one_entry = (count_r == CNT_W'(1));
  assign stat.swap_last = (swaps_r == SWP_W'(1));

endmodule

// ===== hdl/cqr_ctrl.sv =====
`timescale 1ns / 1ps

module cqr_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cqr_pkg::CMD_W-1:0] in_cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  cqr_pkg::dp_stat_t         stat,
  output cqr_pkg::ctl_cmd_t         cmd
);
  import cqr_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ENQ       = 4'd1;
  localparam logic [3:0] S_DEQ_RD    = 4'd2;
  localparam logic [3:0] S_DEQ_CAP   = 4'd3;
  localparam logic [3:0] S_REV_RD_LO = 4'd4;
  localparam logic [3:0] S_REV_RD_HI = 4'd5;
  localparam logic [3:0] S_REV_WR_LO = 4'd6;
  localparam logic [3:0] S_REV_WR_HI = 4'd7;
  localparam logic [3:0] S_FRONT_RD  = 4'd8;
  localparam logic [3:0] S_OUT       = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequence one item through the datapath
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_FRONT_RD;
          unique case (in_cmd)
            CMD_ENQ: begin
              if (stat.full) cmd.err = ERR_OVERFLOW;
              else state_nxt = S_ENQ;
            end
            CMD_DEQ: begin
              if (stat.empty) cmd.err = ERR_UNDERFLOW;
              else state_nxt = S_DEQ_RD;
            end
            CMD_REV: begin
              if (stat.empty) begin
                cmd.err = ERR_UNDERFLOW;
              end else if (!stat.one_entry) begin
                cmd.rev_start = 1'b1;
                state_nxt     = S_REV_RD_LO;
              end
            end
            default: state_nxt = S_FRONT_RD;
          endcase
        end
      end
      S_ENQ: begin
        cmd.mem_wr     = 1'b1;
        cmd.psel       = PSEL_TAIL;
        cmd.enq_commit = 1'b1;
        state_nxt      = S_FRONT_RD;
      end
      S_DEQ_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.psel   = PSEL_HEAD;
        state_nxt  = S_DEQ_CAP;
      end
      S_DEQ_CAP: begin
        cmd.deq_commit = 1'b1;
        state_nxt      = S_FRONT_RD;
      end
      S_REV_RD_LO: begin
        cmd.mem_rd = 1'b1;
        cmd.psel   = PSEL_LO;
        state_nxt  = S_REV_RD_HI;
      end
      S_REV_RD_HI: begin
        cmd.mem_rd    = 1'b1;
        cmd.psel      = PSEL_HI;
        cmd.swap_save = 1'b1;
        state_nxt     = S_REV_WR_LO;
      end
      S_REV_WR_LO: begin
        cmd.mem_wr = 1'b1;
        cmd.psel   = PSEL_LO;
        state_nxt  = S_REV_WR_HI;
      end
      S_REV_WR_HI: begin
        cmd.mem_wr    = 1'b1;
        cmd.psel      = PSEL_HI;
        cmd.swap_step = 1'b1;
        state_nxt     = stat.swap_last ? S_FRONT_RD : S_REV_RD_LO;
      end
      S_FRONT_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.psel   = PSEL_HEAD;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // Wait until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/circular_queue_with_reverse.sv =====
`timescale 1ns / 1ps
// An item is accepted in idle. An error, the unused command or a one-entry reverse goes
// straight to the front read and result load; enqueue first writes at the tail, dequeue
// reads the head and captures it, and a reverse of n first runs floor(n/2) swaps, each
// reading low, reading high, writing low and writing high on the single storage port.
// A result waits until the previous one is taken; no new beat is taken until it loads.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
module circular_queue_with_reverse (
  input logic      clk,
  input logic      rst_n,
  cqr_in_if.sink   in_ch,
  cqr_out_if.source out_ch
);
  import cqr_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  cqr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (dp_stat),
    .cmd       (ctl_cmd)
  );

  cqr_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (ctl_cmd),
    .stat              (dp_stat),
    .in_item_value     (in_ch.item_value),
    .out_removed_value (out_ch.removed_value),
    .out_front_value   (out_ch.front_value),
    .out_entry_count   (out_ch.entry_count),
    .out_is_empty      (out_ch.is_empty),
    .out_is_full       (out_ch.is_full),
    .out_error_code    (out_ch.error_code)
  );

endmodule

// ===== hdl/cqr_checker.sv =====
`timescale 1ns / 1ps

module cqr_sva (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [cqr_pkg::DATA_WIDTH-1:0] out_removed_value,
  input logic signed [cqr_pkg::DATA_WIDTH-1:0] out_front_value,
  input logic [cqr_pkg::CNT_W-1:0]             out_entry_count,
  input logic                                  out_is_empty,
  input logic                                  out_is_full,
  input logic [cqr_pkg::ERR_W-1:0]             out_error_code
);
  import cqr_pkg::*;

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_front_value)
      && $stable(out_entry_count) && $stable(out_removed_value)
      && $stable(out_error_code))
    else $error("result beat changed while stalled");

  // Flags agree with the count
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0))
      && (out_is_full == (out_entry_count == CNT_FULL)))
    else $error("empty/full flags disagree with count");

  // Empty queue reports the minimum word as front
  a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_front_value == INT_MIN)
    else $error("empty queue front value wrong");

  // A full error leaves the queue full
  a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == ERR_OVERFLOW |-> out_is_full && out_removed_value == '0)
    else $error("full error without full queue");

  // An empty error leaves the queue empty and removes nothing
  a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == ERR_UNDERFLOW |-> out_is_empty && out_removed_value == '0)
    else $error("empty error without empty queue");

endmodule

bind circular_queue_with_reverse cqr_sva u_cqr_sva (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_removed_value (out_ch.removed_value),
  .out_front_value   (out_ch.front_value),
  .out_entry_count   (out_ch.entry_count),
  .out_is_empty      (out_ch.is_empty),
  .out_is_full       (out_ch.is_full),
  .out_error_code    (out_ch.error_code)
);

// ===== verif/cqr_checker.sv =====
`timescale 1ns / 1ps

module cqr_checker (
  input  logic clk,
  input  logic rst_n,
  cqr_in_if    in_mon,
  cqr_out_if   out_mon,
  output int   mismatch_count,
  output int   reports_due
);

  import cqr_pkg::*;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] removed_value;
    logic signed [DATA_WIDTH-1:0] front_value;
    logic [CNT_W-1:0]             entry_count;
    logic                         is_empty;
    logic                         is_full;
    logic [ERR_W-1:0]             error_code;
  } queue_report_t;

  // Shadow copy of the ring and its pointers
  logic signed [DATA_WIDTH-1:0] ring [DEPTH];
  logic [PTR_W-1:0]             head_ptr;
  logic [PTR_W-1:0]             tail_ptr;
  logic [CNT_W-1:0]             held;

  queue_report_t report_fifo [$];

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] ptr);
    return (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
  endfunction

  // Apply one command to the shadow queue and return the report it produces
  function automatic queue_report_t apply_command(logic [CMD_W-1:0] op,
                                                  logic signed [DATA_WIDTH-1:0] value);
    queue_report_t                r;
    logic signed [DATA_WIDTH-1:0] flipped [DEPTH];
    logic [PTR_W-1:0]             src;
    int                           k;
    r = '0;
    r.error_code = ERR_NONE;
    case (op)
      CMD_ENQ: begin
        if (held == CNT_FULL) begin
          r.error_code = ERR_OVERFLOW;
        end else begin
          ring[tail_ptr] = value;
          tail_ptr = bump(tail_ptr);
          held = held + 1'b1;
        end
      end
      CMD_DEQ: begin
        if (held == 0) begin
          r.error_code = ERR_UNDERFLOW;
        end else begin
          r.removed_value = ring[head_ptr];
          head_ptr = bump(head_ptr);
          held = held - 1'b1;
        end
      end
      CMD_REV: begin
        if (held == 0) begin
          r.error_code = ERR_UNDERFLOW;
        end else begin
          // Repack newest-first from slot 0
          src = head_ptr;
          for (k = 0; k < int'(held); k++) begin
            flipped[int'(held) - 1 - k] = ring[src];
            src = bump(src);
          end
          for (k = 0; k < int'(held); k++) ring[k] = flipped[k];
          head_ptr = '0;
          tail_ptr = PTR_W'(int'(held) % DEPTH);
        end
      end
      default: begin
        // Unused command: state holds, no error
      end
    endcase
    r.front_value = (held == 0) ? INT_MIN : ring[head_ptr];
    r.entry_count = held;
    r.is_empty    = (held == 0);
    r.is_full     = (held == CNT_FULL);
    return r;
  endfunction

  function automatic void compare_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  initial mismatch_count = 0;

  always @(posedge clk) begin
    queue_report_t want;
    if (!rst_n) begin
      head_ptr = '0;
      tail_ptr = '0;
      held     = '0;
      report_fifo.delete();
    end else begin
      // Predict on every accepted command beat
      if (in_mon.valid && in_mon.ready)
        report_fifo.push_back(apply_command(in_mon.cmd, in_mon.item_value));

      // Compare each accepted result beat against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (report_fifo.size() == 0) begin
          $display({"%0t: unexpected result: expected none, ",
                    "actual removed %0d front %0d count %0d err %0d"},
                   $time, out_mon.removed_value, out_mon.front_value,
                   out_mon.entry_count, out_mon.error_code);
          mismatch_count++;
        end else begin
          want = report_fifo.pop_front();
          compare_field("removed_value", want.removed_value, out_mon.removed_value);
          compare_field("front_value", want.front_value, out_mon.front_value);
          compare_field("entry_count", want.entry_count, out_mon.entry_count);
          compare_field("is_empty", want.is_empty, out_mon.is_empty);
          compare_field("is_full", want.is_full, out_mon.is_full);
          compare_field("error_code", want.error_code, out_mon.error_code);
        end
      end
    end
    reports_due = report_fifo.size();
  end

endmodule

// ===== verif/circular_queue_with_reverse_tb.sv =====
`timescale 1ns / 1ps

module circular_queue_with_reverse_tb;

  import cqr_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;

  localparam logic [CMD_W-1:0]             CMD_UNUSED = 2'd3;
  localparam logic signed [DATA_WIDTH-1:0] INT_MAX    = ~INT_MIN;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   reports_due;
  int   quiet_cycles;
  bit   send_burst;
  bit   take_burst;

  cqr_in_if  in_ch ();
  cqr_out_if out_ch ();

  circular_queue_with_reverse dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cqr_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .reports_due    (reports_due)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: end the run when no beat moves for too long
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one command beat after a random gap and hold it until taken
  task automatic send_cmd(logic [CMD_W-1:0] op, logic signed [DATA_WIDTH-1:0] value);
    int gap;
    if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= op;
    in_ch.item_value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Fill phases lean on enqueue, drain phases on dequeue
  function automatic logic [CMD_W-1:0] pick_cmd(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (r < (filling ? 60 : 25)) return CMD_ENQ;
    if (r < 85)                  return CMD_DEQ;
    if (r < 97)                  return CMD_REV;
    return CMD_UNUSED;
  endfunction

  // Result side: stall at random before each beat
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Command side: reset, directed corners, then random traffic
  initial begin
    int n;
    int phase_left;
    bit filling;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_ENQ;
    in_ch.item_value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Errors and the unused command on an empty queue
    send_cmd(CMD_REV, 32'sd5);
    send_cmd(CMD_DEQ, 32'sd7);
    send_cmd(CMD_UNUSED, INT_MAX);
    // Extreme values, then reverse, dequeue and the unused command with entries held
    send_cmd(CMD_ENQ, INT_MIN);
    send_cmd(CMD_ENQ, INT_MAX);
    send_cmd(CMD_ENQ, '0);
    send_cmd(CMD_ENQ, '1);
    send_cmd(CMD_REV, '0);
    send_cmd(CMD_DEQ, '0);
    send_cmd(CMD_UNUSED, '1);
    // Fill past the wrap point to full, overflow, reverse a wrapped ring, drain one
    for (n = 0; n < 13; n++)
      send_cmd(CMD_ENQ, n[0] ? 32'sh5555_5555 ^ n : 32'shAAAA_AAAA ^ n);
    send_cmd(CMD_ENQ, 32'sh1234_5678);
    send_cmd(CMD_REV, '0);
    send_cmd(CMD_DEQ, '0);

    // Random traffic in alternating fill and drain phases
    filling    = 1'b1;
    phase_left = $urandom_range(20, 60);
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      send_cmd(pick_cmd(filling), pick_value());
    end
    in_ch.valid <= 1'b0;

    // Let the last results drain, then watch for strays
    @(posedge clk);
    wait (reports_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
